// ----- rtl/itda_pkg.sv -----
// Shared types and constants for the integer to decimal ASCII converter.
package itda_pkg;

  // Control word broadcast to every BCD digit cell.
  typedef struct packed {
    logic clear;   // zero the digit
    logic dabble;  // add-3 correction, then shift in one binary bit
    logic shift;   // take the digit of the lower neighbor
  } cell_ctl_t;

  localparam logic [6:0] CHAR_MINUS = 7'd45;
  localparam logic [6:0] CHAR_ZERO  = 7'd48;

endpackage

// ----- rtl/itda_cell.sv -----
// One BCD digit cell of the double-dabble chain.
module itda_cell import itda_pkg::*; (
  input  logic       clk,
  input  cell_ctl_t  ctl,
  input  logic       bit_in,    // carry from the lower cell (or the binary MSB)
  input  logic [3:0] digit_in,  // digit of the lower cell
  output logic       bit_out,   // carry to the upper cell
  output logic [3:0] digit
);

  logic [3:0] adj;

  assign adj     = (digit >= 4'd5) ? digit + 4'd3 : digit;
  assign bit_out = adj[3];

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      digit <= 4'd0;
    end else if (ctl.dabble) begin
      digit <= {adj[2:0], bit_in};
    end else if (ctl.shift) begin
      digit <= digit_in;
    end
  end

endmodule

// ----- rtl/int_to_decimal_ascii.sv -----
// Top level: signed integer to decimal ASCII text, one character per transaction.
//
//   channel  dir  handshake           payload
//   s_*      in   s_tvalid/s_tready   s_tdata: value (VALUE_BITS, signed)
//   m_*      out  m_tvalid/m_tready   m_tdata: character (7), tlast: last char
//
// An item is loaded, shifted bit by bit with shift-and-add-3 through the row of digit
// cells, passed through the skip state (dropping leading zeros), then emitted at one
// character per cycle while the output is not stalled.
// The next item is taken as soon as the last character sits in the output register.
// Reset (rst, synchronous) returns the controller to idle and empties the output.
module int_to_decimal_ascii import itda_pkg::*; #(
  parameter int VALUE_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [((VALUE_BITS + 7) / 8)*8-1:0] s_tdata,   // [VALUE_BITS-1:0] value
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [7:0]                          m_tdata,   // [6:0] character, [7] zero
  output logic                                m_tlast
);

  localparam int ND  = (VALUE_BITS * 3 + 9) / 10;  // enough digits for 2^(VALUE_BITS-1)
  localparam int BCW = $clog2(VALUE_BITS + 1);
  localparam int DCW = $clog2(ND + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CONV = 2'd1;
  localparam logic [1:0] S_SKIP = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]            state;
  logic [VALUE_BITS-1:0] mag;
  logic [BCW-1:0]        bitcnt;
  logic [DCW-1:0]        digcnt;
  logic                  neg_pend;
  logic [6:0]            out_char;
  logic                  out_valid;
  logic                  out_last;

  logic [VALUE_BITS-1:0] value;
  logic                  accept;
  logic                  out_free;
  logic                  skip_zero;
  logic                  emit_digit;
  cell_ctl_t             ctl;
  logic [3:0]            dig   [ND];
  logic                  carry [ND+1];
  logic [3:0]            top_digit;

  assign value     = s_tdata[VALUE_BITS-1:0];
  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !out_valid || m_tready;
  assign top_digit = dig[ND-1];
  assign skip_zero = (state == S_SKIP) && (top_digit == 4'd0) && (digcnt > DCW'(1));
  assign emit_digit = (state == S_EMIT) && out_free && !neg_pend;

  assign ctl.clear  = accept;
  assign ctl.dabble = (state == S_CONV);
  assign ctl.shift  = skip_zero || emit_digit;

  assign carry[0] = mag[VALUE_BITS-1];

  for (genvar i = 0; i < ND; i++) begin : g_cell
    itda_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .bit_in   (carry[i]),
      .digit_in ((i == 0) ? 4'd0 : dig[(i == 0) ? 0 : i-1]),
      .bit_out  (carry[i+1]),
      .digit    (dig[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      neg_pend  <= 1'b0;
    end else begin
      // the emit state refills the register itself whenever it is free
      if (out_valid && m_tready && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            mag      <= value[VALUE_BITS-1] ? (~value + 1'b1) : value;
            neg_pend <= value[VALUE_BITS-1];
            bitcnt   <= BCW'(VALUE_BITS);
            state    <= S_CONV;
          end
        end
        S_CONV: begin
          mag    <= mag << 1;
          bitcnt <= bitcnt - 1'b1;
          if (bitcnt == BCW'(1)) begin
            digcnt <= DCW'(ND);
            state  <= S_SKIP;
          end
        end
        S_SKIP: begin
          // drop leading zeros, keep at least one digit
          if (skip_zero) begin
            digcnt <= digcnt - 1'b1;
          end else begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            if (neg_pend) begin
              out_char <= CHAR_MINUS;
              out_last <= 1'b0;
              neg_pend <= 1'b0;
            end else begin
              out_char <= CHAR_ZERO + {3'b000, top_digit};
              out_last <= (digcnt == DCW'(1));
              digcnt   <= digcnt - 1'b1;
              if (digcnt == DCW'(1)) begin
                state <= S_IDLE;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_char};
  assign m_tlast  = out_last;

  a_accept_conv: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_CONV))
    else $error("accepted item did not start conversion");

  a_conv_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_CONV) |-> (bitcnt != '0))
    else $error("conversion running with empty bit count");

  a_final_char: assert property (@(posedge clk) disable iff (rst)
    (emit_digit && digcnt == DCW'(1)) |=> (state == S_IDLE && m_tvalid && m_tlast))
    else $error("final digit not flagged last");

  a_last_digit: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tdata[6:0] != CHAR_MINUS))
    else $error("minus sign flagged as last character");

  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    emit_digit |-> (top_digit <= 4'd9))
    else $error("BCD digit out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (state == S_CONV) |-> !carry[ND])
    else $error("carry out of the top digit cell");

endmodule
